// ===== design/hmkr_pkg.sv =====
// ----------------------------------------------------------------------------
// hmkr_pkg: shared types and constants for the header mask key ratchet
// Holds the action codes, the header field layout, the hash constants and
// the status bundle that the hash sequencer reports to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hmkr_pkg;

    // Action codes carried on the action field of an input beat.
    typedef enum logic [1:0] {
        ACT_MASK   = 2'd0,
        ACT_UNMASK = 2'd1,
        ACT_LOAD   = 2'd2,
        ACT_HELLO  = 2'd3
    } t_action;

    // Header field widths.
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned LEN_W   = 22;
    localparam int unsigned RSV_W   = 2;
    localparam int unsigned CMD_W   = 5;

    // Bit positions of the fields within the packed header word.
    localparam int unsigned RSV_LSB = 22;
    localparam int unsigned SIG_BIT = 24;
    localparam int unsigned PUB_BIT = 25;
    localparam int unsigned CHN_BIT = 26;
    localparam int unsigned CMD_LSB = 27;

    // Hash constants for one word of input.
    localparam logic [KEY_W-1:0] HASH_SEED = 32'hb10cfeed;
    localparam logic [KEY_W-1:0] HASH_C1   = 32'hcc9e2d51;
    localparam logic [KEY_W-1:0] HASH_C2   = 32'h1b873593;
    localparam logic [KEY_W-1:0] HASH_MUL5 = 32'd5;
    localparam logic [KEY_W-1:0] HASH_ADD  = 32'he6546b64;
    localparam logic [KEY_W-1:0] HASH_LEN  = 32'd4;
    localparam logic [KEY_W-1:0] HASH_F1   = 32'h85ebca6b;
    localparam logic [KEY_W-1:0] HASH_F2   = 32'hc2b2ae35;

    // Status of the hash sequencer as seen by the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } t_hash_stat;

endpackage

`default_nettype wire

// ===== design/header_mask_key_ratchet.sv =====
// ----------------------------------------------------------------------------
// header_mask_key_ratchet: frame header masking with a ratcheting key
// Masks and unmasks 4-byte frame headers with a 32-bit key and advances the
// key by a one-word hash after every mask or unmask.
// ----------------------------------------------------------------------------
// On a mask or unmask beat the masked or unmasked result is registered at
// once, while the key ratchet runs six steps in the hash sequencer, all but
// the add step through one shared 32x32 multiplier, and the new key is then
// written back. The input stalls
// while the key is being ratcheted and while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module header_mask_key_ratchet (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output      logic [31:0]                         prdata,
    output      logic                                pready,

    // Input channel.
    input  wire logic                                i_in_valid,
    output      logic                                o_in_stall,
    input  wire logic [1:0]                          i_action,
    input  wire logic [hmkr_pkg::LEN_W-1:0]          i_cmd_len,
    input  wire logic [hmkr_pkg::RSV_W-1:0]          i_reserved_bits,
    input  wire logic                                i_signed_flag,
    input  wire logic                                i_pubkey_flag,
    input  wire logic                                i_channel_flag,
    input  wire logic [hmkr_pkg::CMD_W-1:0]          i_proto_cmd,
    input  wire logic [hmkr_pkg::KEY_W-1:0]          i_masked_word,
    input  wire logic [hmkr_pkg::KEY_W-1:0]          i_new_key,

    // Output channel.
    output      logic                                o_out_valid,
    input  wire logic                                i_out_stall,
    output      logic [hmkr_pkg::KEY_W-1:0]          o_word_out,
    output      logic [hmkr_pkg::LEN_W-1:0]          o_len_out,
    output      logic [hmkr_pkg::RSV_W-1:0]          o_reserved_out,
    output      logic                                o_signed_out,
    output      logic                                o_pubkey_out,
    output      logic                                o_channel_out,
    output      logic [hmkr_pkg::CMD_W-1:0]          o_cmd_out
);

    logic [hmkr_pkg::KEY_W-1:0]  r_key;
    logic [hmkr_pkg::KEY_W-1:0]  r_hello_key;
    logic                        r_busy;
    logic                        r_out_valid;
    logic [hmkr_pkg::KEY_W-1:0]  r_word_out;
    logic [hmkr_pkg::LEN_W-1:0]  r_len_out;
    logic [hmkr_pkg::RSV_W-1:0]  r_reserved_out;
    logic                        r_signed_out;
    logic                        r_pubkey_out;
    logic                        r_channel_out;
    logic [hmkr_pkg::CMD_W-1:0]  r_cmd_out;

    hmkr_pkg::t_action           w_action;
    hmkr_pkg::t_hash_stat        w_hash_stat;
    logic [hmkr_pkg::KEY_W-1:0]  w_hash;
    logic                        w_in_acc;
    logic                        w_out_acc;
    logic                        w_ratchet;
    logic                        w_cfg_wr;
    logic [hmkr_pkg::KEY_W-1:0]  w_packed;
    logic [hmkr_pkg::KEY_W-1:0]  w_plain;

    // Configuration register: hello key at any address with paddr[2] low (0 to 3).
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? r_hello_key : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hello_key <= '0;
        end else if (w_cfg_wr) begin
            r_hello_key <= pwdata;
        end
    end

    // Handshakes: one item at a time, with a free output register.
    assign w_action   = hmkr_pkg::t_action'(i_action);
    assign o_in_stall = r_busy || (r_out_valid && i_out_stall);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign w_ratchet  = w_in_acc &&
                        ((w_action == hmkr_pkg::ACT_MASK) ||
                         (w_action == hmkr_pkg::ACT_UNMASK));

    // Header packing and unmasking against the current key.
    assign w_packed = {i_proto_cmd, i_channel_flag, i_pubkey_flag, i_signed_flag,
                       i_reserved_bits, i_cmd_len} ^ r_key;
    assign w_plain  = i_masked_word ^ r_key;

    // Key ratchet sequencer.
    hmkr_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ratchet),
        .i_key   (r_key),
        .o_stat  (w_hash_stat),
        .o_hash  (w_hash)
    );

    // Key register and the busy flag that covers the ratchet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_busy <= 1'b0;
        end else begin
            if (w_hash_stat.done) begin
                r_key  <= w_hash;
                r_busy <= 1'b0;
            end else if (w_in_acc) begin
                unique case (w_action)
                    hmkr_pkg::ACT_MASK,
                    hmkr_pkg::ACT_UNMASK: r_busy <= 1'b1;
                    hmkr_pkg::ACT_LOAD:   r_key  <= i_new_key;
                    hmkr_pkg::ACT_HELLO:  r_key  <= r_hello_key;
                    default:              r_busy <= r_busy;
                endcase
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ratchet) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, loaded when a mask or unmask beat is taken.
    always_ff @(posedge i_clk) begin
        if (w_ratchet) begin
            if (w_action == hmkr_pkg::ACT_MASK) begin
                r_word_out     <= w_packed;
                r_len_out      <= '0;
                r_reserved_out <= '0;
                r_signed_out   <= 1'b0;
                r_pubkey_out   <= 1'b0;
                r_channel_out  <= 1'b0;
                r_cmd_out      <= '0;
            end else begin
                r_word_out     <= '0;
                r_len_out      <= w_plain[hmkr_pkg::LEN_W-1:0];
                r_reserved_out <= w_plain[hmkr_pkg::RSV_LSB +: hmkr_pkg::RSV_W];
                r_signed_out   <= w_plain[hmkr_pkg::SIG_BIT];
                r_pubkey_out   <= w_plain[hmkr_pkg::PUB_BIT];
                r_channel_out  <= w_plain[hmkr_pkg::CHN_BIT];
                r_cmd_out      <= w_plain[hmkr_pkg::CMD_LSB +: hmkr_pkg::CMD_W];
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_word_out     = r_word_out;
    assign o_len_out      = r_len_out;
    assign o_reserved_out = r_reserved_out;
    assign o_signed_out   = r_signed_out;
    assign o_pubkey_out   = r_pubkey_out;
    assign o_channel_out  = r_channel_out;
    assign o_cmd_out      = r_cmd_out;

    // A mask or unmask beat keeps the block busy until the new key lands.
    a_busy_after_ratchet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ratchet |=> (r_busy && w_hash_stat.busy))
        else $error("ratchet started without busy");

    // The input is held off for the whole ratchet.
    a_stall_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hash_stat.busy |-> o_in_stall)
        else $error("input open while hashing");

    // Hash completion only ever closes a ratchet in progress.
    a_done_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hash_stat.done |-> r_busy)
        else $error("hash done without a ratchet in progress");

    // A result appears only as a consequence of an accepted mask or unmask.
    a_result_from_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_ratchet))
        else $error("result without a source beat");

endmodule

`default_nettype wire

// ===== design/hmkr_hash.sv =====
// ----------------------------------------------------------------------------
// hmkr_hash: iterative one-word hash of the header key
// A small sequencer drives one shared 32x32 multiplier through the hash
// rounds. The first multiply happens on the start cycle; five further steps
// follow, and the final shift-xor is applied on the way out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmkr_hash (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [hmkr_pkg::KEY_W-1:0]    i_key,
    output      hmkr_pkg::t_hash_stat          o_stat,
    output      logic [hmkr_pkg::KEY_W-1:0]    o_hash
);

    // Steps that follow the start cycle.
    typedef enum logic [2:0] {
        ST_K2,
        ST_H5,
        ST_HADD,
        ST_F1,
        ST_F2
    } t_step;

    t_step                       r_step;
    logic                        r_busy;
    logic                        r_done;
    logic [hmkr_pkg::KEY_W-1:0]  r_acc;

    logic [hmkr_pkg::KEY_W-1:0]  w_op_a;
    logic [hmkr_pkg::KEY_W-1:0]  w_op_b;
    logic [2*hmkr_pkg::KEY_W-1:0] w_prod_full;
    logic [hmkr_pkg::KEY_W-1:0]  w_prod;
    logic [hmkr_pkg::KEY_W-1:0]  w_seeded;
    logic [hmkr_pkg::KEY_W-1:0]  n_acc;

    // Operand selection for the shared multiplier.
    assign w_seeded = hmkr_pkg::HASH_SEED ^ r_acc;

    always_comb begin
        w_op_a = r_acc;
        w_op_b = hmkr_pkg::HASH_C1;
        if (i_start) begin
            w_op_a = i_key;
            w_op_b = hmkr_pkg::HASH_C1;
        end else begin
            unique case (r_step)
                ST_K2: begin
                    w_op_a = {r_acc[16:0], r_acc[31:17]};
                    w_op_b = hmkr_pkg::HASH_C2;
                end
                ST_H5: begin
                    w_op_a = {w_seeded[18:0], w_seeded[31:19]};
                    w_op_b = hmkr_pkg::HASH_MUL5;
                end
                ST_HADD: begin
                    w_op_a = r_acc;
                    w_op_b = hmkr_pkg::HASH_C1;
                end
                ST_F1: begin
                    w_op_a = r_acc ^ {16'd0, r_acc[31:16]};
                    w_op_b = hmkr_pkg::HASH_F1;
                end
                ST_F2: begin
                    w_op_a = r_acc ^ {13'd0, r_acc[31:13]};
                    w_op_b = hmkr_pkg::HASH_F2;
                end
                default: begin
                    w_op_a = r_acc;
                    w_op_b = hmkr_pkg::HASH_C1;
                end
            endcase
        end
    end

    // The one multiplier; only the low word is kept.
    assign w_prod_full = w_op_a * w_op_b;
    assign w_prod      = w_prod_full[hmkr_pkg::KEY_W-1:0];

    // The add step bypasses the multiplier.
    always_comb begin
        if (!i_start && (r_step == ST_HADD)) begin
            n_acc = (r_acc + hmkr_pkg::HASH_ADD) ^ hmkr_pkg::HASH_LEN;
        end else begin
            n_acc = w_prod;
        end
    end

    // Sequencer state and the accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_K2;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_step <= ST_K2;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                unique case (r_step)
                    ST_K2:   r_step <= ST_H5;
                    ST_H5:   r_step <= ST_HADD;
                    ST_HADD: r_step <= ST_F1;
                    ST_F1:   r_step <= ST_F2;
                    ST_F2: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                    default: r_step <= ST_K2;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start || r_busy) begin
            r_acc <= n_acc;
        end
    end

    // Final avalanche shift-xor on the way out.
    assign o_hash      = r_acc ^ {16'd0, r_acc[31:16]};
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    // A new hash must never be started over one still in progress.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("hash started while busy");

    // Completion is flagged only once the sequencer has gone idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_busy && $past(r_busy) && ($past(r_step) == ST_F2)))
        else $error("hash done outside the last step");

endmodule

`default_nettype wire
